// ----- hdl/jlp_pkg.sv -----
// Shared constants, control word types and the microcode table of the position loop.
`default_nettype none

package jlp_pkg;

    // Sizes of the block
    localparam int AXES     = 3;
    localparam int NUM_REGS = 3;
    localparam int AXIS_W   = 2;
    localparam int IDX_W    = 2;
    localparam int KIN_W    = 32;
    localparam int DT_W     = 24;
    localparam int SET_W    = 64;
    localparam int STEP_W   = 4;

    // Datapath widths
    localparam int ERR_W    = KIN_W + 1;     // exact difference of two Q16.16 values
    localparam int MA_W     = 34;            // shared multiplier, operand A (signed)
    localparam int MB_W     = 25;            // shared multiplier, operand B (signed)
    localparam int PROD_W   = MA_W + MB_W;
    localparam int JERK_W   = 52;            // sum of three gain products, Q.24
    localparam int MAG_W    = 36;            // clamped jerk magnitude, Q.24
    localparam int HALF_W   = 18;            // magnitude split for the dt product
    localparam int PP_W     = HALF_W + DT_W; // one partial product of mag * dt
    localparam int T_W      = 60;            // mag * dt plus rounding constant, Q.48
    localparam int RND_W    = T_W - 32;      // rounded step, Q12.16
    localparam int SUM_W    = KIN_W + 2;

    localparam logic [T_W-1:0] RND_HALF = T_W'(64'h8000_0000);

    // Operand A select
    localparam logic [2:0] A_NONE = 3'd0;
    localparam logic [2:0] A_EP   = 3'd1;
    localparam logic [2:0] A_EV   = 3'd2;
    localparam logic [2:0] A_EA   = 3'd3;
    localparam logic [2:0] A_MLO  = 3'd4;
    localparam logic [2:0] A_MHI  = 3'd5;

    // Operand B select
    localparam logic [2:0] B_NONE = 3'd0;
    localparam logic [2:0] B_KP   = 3'd1;
    localparam logic [2:0] B_KV   = 3'd2;
    localparam logic [2:0] B_KA   = 3'd3;
    localparam logic [2:0] B_DT   = 3'd4;

    // Jerk accumulator operation
    localparam logic [1:0] J_HOLD = 2'd0;
    localparam logic [1:0] J_LOAD = 2'd1;
    localparam logic [1:0] J_ADD  = 2'd2;

    // Step product register operation
    localparam logic [1:0] T_HOLD = 2'd0;
    localparam logic [1:0] T_LOAD = 2'd1;
    localparam logic [1:0] T_ADD  = 2'd2;

    localparam logic [STEP_W-1:0] FIN_STEP = STEP_W'(8);

    typedef struct packed {
        logic [2:0]        a_sel;
        logic [2:0]        b_sel;
        logic [1:0]        j_op;
        logic              clamp;
        logic [1:0]        t_op;
        logic              jmp_bad;
        logic [STEP_W-1:0] target;
        logic              fin;
    } t_uword;

    typedef struct packed {
        logic   run;
        logic   commit;
        t_uword uw;
    } t_ctrl;

    // Microcode table: one control word per step
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{a_sel: A_NONE, b_sel: B_NONE, j_op: J_HOLD, clamp: 1'b0,
              t_op: T_HOLD, jmp_bad: 1'b0, target: FIN_STEP, fin: 1'b0};
        case (step)
            4'd0: begin
                w.a_sel   = A_EP;
                w.b_sel   = B_KP;
                w.jmp_bad = 1'b1;
            end
            4'd1: begin
                w.a_sel = A_EV;
                w.b_sel = B_KV;
                w.j_op  = J_LOAD;
            end
            4'd2: begin
                w.a_sel = A_EA;
                w.b_sel = B_KA;
                w.j_op  = J_ADD;
            end
            4'd3: begin
                w.j_op = J_ADD;
            end
            4'd4: begin
                w.clamp = 1'b1;
            end
            4'd5: begin
                w.a_sel = A_MLO;
                w.b_sel = B_DT;
            end
            4'd6: begin
                w.a_sel = A_MHI;
                w.b_sel = B_DT;
                w.t_op  = T_LOAD;
            end
            4'd7: begin
                w.t_op = T_ADD;
            end
            default: begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/jlp_ifs.sv -----
// Valid/ready channel interfaces: input sample, result command and settings write.
`default_nettype none

interface jlp_in_if import jlp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [AXIS_W-1:0]        axis;
    logic signed [KIN_W-1:0]  current_position;
    logic signed [KIN_W-1:0]  current_velocity;
    logic signed [KIN_W-1:0]  current_acceleration;
    logic signed [KIN_W-1:0]  target_position;
    logic signed [KIN_W-1:0]  target_velocity;
    logic signed [KIN_W-1:0]  target_acceleration;
    logic [DT_W-1:0]          time_step;

    modport source (
        output valid, axis, current_position, current_velocity, current_acceleration,
               target_position, target_velocity, target_acceleration, time_step,
        input  ready
    );
    modport sink (
        input  valid, axis, current_position, current_velocity, current_acceleration,
               target_position, target_velocity, target_acceleration, time_step,
        output ready
    );
endinterface

interface jlp_out_if import jlp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [AXIS_W-1:0]        result_axis;
    logic signed [KIN_W-1:0]  acceleration_command;

    modport source (output valid, result_axis, acceleration_command, input ready);
    modport sink   (input valid, result_axis, acceleration_command, output ready);
endinterface

interface jlp_cfg_if import jlp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [SET_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/jlp_useq.sv -----
// Microcode sequencer: step counter, control table lookup and conditional jump.
`default_nettype none

module jlp_useq import jlp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_bad,
    input  logic  i_out_free,
    output logic  o_idle,
    output t_ctrl o_ctrl
);

    logic              r_busy;
    logic              n_busy;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              commit;
    t_uword            uw;

    assign uw = ucode(r_step);

    // Advance, jump or hold the program
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        commit = 1'b0;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = '0;
            end
        end else if (uw.fin) begin
            // hold on the last step until the result register is free
            if (i_out_free) begin
                commit = 1'b1;
                n_busy = 1'b0;
            end
        end else if (uw.jmp_bad && i_bad) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_idle        = !r_busy;
    assign o_ctrl.run    = r_busy;
    assign o_ctrl.commit = commit;
    assign o_ctrl.uw     = uw;

endmodule

`default_nettype wire

// ----- hdl/jlp_dpath.sv -----
// Datapath: settings, per-axis accumulators, shared multiplier, clamp and result register.
`default_nettype none

module jlp_dpath import jlp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl                   i_ctrl,
    // sample capture
    input  logic                    i_start,
    input  logic [AXIS_W-1:0]       i_axis,
    input  logic signed [KIN_W-1:0] i_cur_pos,
    input  logic signed [KIN_W-1:0] i_cur_vel,
    input  logic signed [KIN_W-1:0] i_cur_acc,
    input  logic signed [KIN_W-1:0] i_tgt_pos,
    input  logic signed [KIN_W-1:0] i_tgt_vel,
    input  logic signed [KIN_W-1:0] i_tgt_acc,
    input  logic [DT_W-1:0]         i_dt,
    // settings write
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_idx,
    input  logic [SET_W-1:0]        i_cfg_data,
    // result word
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [AXIS_W-1:0]       o_out_axis,
    output logic signed [KIN_W-1:0] o_out_cmd,
    output logic                    o_out_free,
    output logic                    o_bad
);

    logic [SET_W-1:0]        r_set [AXES];
    logic signed [KIN_W-1:0] r_acc [AXES];

    logic [AXIS_W-1:0]        r_axis;
    logic signed [ERR_W-1:0]  r_ep;
    logic signed [ERR_W-1:0]  r_ev;
    logic signed [ERR_W-1:0]  r_ea;
    logic [DT_W-1:0]          r_dt;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [JERK_W-1:0] r_jerk;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [T_W-1:0]           r_t;
    logic                     r_out_valid;
    logic [AXIS_W-1:0]        r_out_axis;
    logic signed [KIN_W-1:0]  r_out_cmd;

    logic                     bad;
    logic [SET_W-1:0]         set_sel;
    logic signed [KIN_W-1:0]  acc_sel;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [JERK_W-1:0] maxj;
    logic [MAG_W-1:0]         n_mag;
    logic                     n_neg;
    logic [RND_W-1:0]         rnd;
    logic signed [SUM_W-1:0]  delta;
    logic signed [SUM_W-1:0]  sum;
    logic signed [KIN_W-1:0]  sat;

    assign bad = int'(r_axis) >= AXES;

    // Select the settings and accumulator of the active axis
    always_comb begin
        set_sel = '0;
        acc_sel = '0;
        if (!bad) begin
            set_sel = r_set[r_axis];
            acc_sel = r_acc[r_axis];
        end
    end

    // Operand selection for the shared multiplier
    always_comb begin
        case (i_ctrl.uw.a_sel)
            A_EP:    mul_a = MA_W'(r_ep);
            A_EV:    mul_a = MA_W'(r_ev);
            A_EA:    mul_a = MA_W'(r_ea);
            A_MLO:   mul_a = MA_W'({1'b0, r_mag[HALF_W-1:0]});
            A_MHI:   mul_a = MA_W'({1'b0, r_mag[MAG_W-1:HALF_W]});
            default: mul_a = '0;
        endcase
        case (i_ctrl.uw.b_sel)
            B_KP:    mul_b = MB_W'({1'b0, set_sel[15:0]});
            B_KV:    mul_b = MB_W'({1'b0, set_sel[31:16]});
            B_KA:    mul_b = MB_W'({1'b0, set_sel[47:32]});
            B_DT:    mul_b = MB_W'({1'b0, r_dt});
            default: mul_b = '0;
        endcase
    end

    assign prod = mul_a * mul_b;

    // Clamp the jerk to plus or minus max jerk (Q12.4 shifted to Q.24)
    assign maxj = $signed(JERK_W'({set_sel[63:48], 20'b0}));

    always_comb begin
        if (r_jerk > maxj) begin
            n_mag = MAG_W'(maxj);
            n_neg = 1'b0;
        end else if (r_jerk < -maxj) begin
            n_mag = MAG_W'(maxj);
            n_neg = 1'b1;
        end else if (r_jerk[JERK_W-1]) begin
            n_mag = MAG_W'(-r_jerk);
            n_neg = 1'b1;
        end else begin
            n_mag = MAG_W'(r_jerk);
            n_neg = 1'b0;
        end
    end

    // Apply the sign to the rounded step and saturate the new command
    assign rnd   = r_t[T_W-1:32];
    assign delta = r_neg ? -$signed(SUM_W'(rnd)) : $signed(SUM_W'(rnd));
    assign sum   = SUM_W'(acc_sel) + delta;

    always_comb begin
        if (sum[SUM_W-1:KIN_W-1] == '0 || sum[SUM_W-1:KIN_W-1] == '1) begin
            sat = sum[KIN_W-1:0];
        end else if (sum[SUM_W-1]) begin
            sat = {1'b1, {(KIN_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(KIN_W-1){1'b1}}};
        end
    end

    // Settings and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_set[i] <= '0;
                r_acc[i] <= '0;
            end
        end else begin
            if (i_cfg_we && int'(i_cfg_idx) < NUM_REGS && int'(i_cfg_idx) < AXES) begin
                r_set[i_cfg_idx] <= i_cfg_data;
            end
            if (i_ctrl.commit && !bad) begin
                r_acc[r_axis] <= sat;
            end
        end
    end

    // Capture the sample and form the exact errors
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_axis <= i_axis;
            r_ep   <= ERR_W'(i_tgt_pos) - ERR_W'(i_cur_pos);
            r_ev   <= ERR_W'(i_tgt_vel) - ERR_W'(i_cur_vel);
            r_ea   <= ERR_W'(i_tgt_acc) - ERR_W'(i_cur_acc);
            r_dt   <= i_dt;
        end
    end

    // Working registers driven by the control word
    always_ff @(posedge i_clk) begin
        if (i_ctrl.run) begin
            r_prod <= prod;
            case (i_ctrl.uw.j_op)
                J_LOAD:  r_jerk <= $signed(r_prod[JERK_W-1:0]);
                J_ADD:   r_jerk <= r_jerk + $signed(r_prod[JERK_W-1:0]);
                default: r_jerk <= r_jerk;
            endcase
            if (i_ctrl.uw.clamp) begin
                r_mag <= n_mag;
                r_neg <= n_neg;
            end
            case (i_ctrl.uw.t_op)
                T_LOAD:  r_t <= T_W'(r_prod[PP_W-1:0]) + RND_HALF;
                T_ADD:   r_t <= r_t + {r_prod[PP_W-1:0], {HALF_W{1'b0}}};
                default: r_t <= r_t;
            endcase
        end
    end

    // Result register: load on commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_out_axis <= r_axis;
            r_out_cmd  <= bad ? '0 : sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_axis  = r_out_axis;
    assign o_out_cmd   = r_out_cmd;
    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_bad       = bad;

endmodule

`default_nettype wire

// ----- hdl/jerk_limited_pdd2_position_loop.sv -----
// Top level of the jerk-limited PDD2 position loop: sequencer plus datapath.
// Each accepted word runs the nine-step microprogram, which passes five multiplies through one
// shared 34x25 multiplier; an axis index out of range jumps from the first step to the last.
// The input is not ready for the next word until the current one has finished its last step.
// A waiting result does not block the next input word; the last step holds only if it is still there.
// Reset (i_rst_n low, synchronous) clears the settings, all axis accumulators and the result valid.
`default_nettype none

module jerk_limited_pdd2_position_loop import jlp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jlp_in_if.sink    i_in,
    jlp_out_if.source o_out,
    jlp_cfg_if.sink   i_cfg
);

    logic  idle;
    logic  start;
    logic  bad;
    logic  out_free;
    t_ctrl ctrl;

    assign i_in.ready  = idle;
    assign start       = i_in.valid && idle;
    assign i_cfg.ready = 1'b1;

    jlp_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_bad      (bad),
        .i_out_free (out_free),
        .o_idle     (idle),
        .o_ctrl     (ctrl)
    );

    jlp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_start     (start),
        .i_axis      (i_in.axis),
        .i_cur_pos   (i_in.current_position),
        .i_cur_vel   (i_in.current_velocity),
        .i_cur_acc   (i_in.current_acceleration),
        .i_tgt_pos   (i_in.target_position),
        .i_tgt_vel   (i_in.target_velocity),
        .i_tgt_acc   (i_in.target_acceleration),
        .i_dt        (i_in.time_step),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_axis  (o_out.result_axis),
        .o_out_cmd   (o_out.acceleration_command),
        .o_out_free  (out_free),
        .o_bad       (bad)
    );

endmodule

`default_nettype wire

// ----- hdl/jlp_checker.sv -----
// Port-level checker for the position loop and its bind to the top level.
`default_nettype none

module jlp_checker import jlp_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [AXIS_W-1:0]       i_out_axis,
    input logic signed [KIN_W-1:0] i_out_cmd
);

    // A stalled result word holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_axis) && $stable(i_out_cmd))
        else $error("result word changed while stalled");

    // The block goes busy right after it takes a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input still ready after a word was taken");

    // A new result only appears at the end of work on a word
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while the block was idle");

    // An axis index out of range gives a zero command
    a_bad_axis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && int'(i_out_axis) >= AXES |-> i_out_cmd == '0)
        else $error("nonzero command for an axis out of range");

    // Reset clears the result valid
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid survived reset");

endmodule

bind jerk_limited_pdd2_position_loop jlp_checker u_jlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_axis  (o_out.result_axis),
    .i_out_cmd   (o_out.acceleration_command)
);

`default_nettype wire
